// File: hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

  // Fixed field widths of the request, response and capacity register
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 4;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Request payload
  typedef struct packed {
    logic                      opcode;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } lkv_req_t;

  // Response payload
  typedef struct packed {
    logic                      hit;
    logic signed [VALUE_W-1:0] read_value;
    logic                      evicted;
  } lkv_rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic cfg_write;
    logic match;
    logic update;
    logic finish;
  } lkv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rsp_busy;
  } lkv_sts_t;

endpackage

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+-------------------------------
//  request  | req_valid, req_ready, req        | opcode, key, value
//  response | rsp_valid, rsp_ready, rsp        | hit, read_value, evicted
//  config   | cfg_valid, cfg_ready, cfg_capacity | capacity (clears the store)
//
// Each access runs through capture, parallel key compare over all lanes, rank and
// store update with the value RAM access, then the response load.
// A new request is taken once the previous response is loaded, even while that
// response still waits for its transfer; the finish step holds while it waits.
// A capacity write clears the valid bits, ranks and fill count.
// Reset leaves capacity at 8 and the store empty; no clearing pass is needed.
module lru_key_value_cache #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  lkv_pkg::lkv_req_t          req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output lkv_pkg::lkv_rsp_t          rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_capacity
);

  import lkv_pkg::*;

  lkv_cmd_t cmd;
  lkv_sts_t sts;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg_capacity (cfg_capacity),
    .cmd          (cmd),
    .sts          (sts),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp)
  );

endmodule

// File: hw/rtl/lkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/lkv_ctrl.sv
// Sequencing state machine for the LRU key-value cache.
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  lkv_pkg::lkv_sts_t sts,
  output lkv_pkg::lkv_cmd_t cmd
);

  import lkv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_UPDATE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   idle;

  assign idle      = (state == S_IDLE);
  // Configuration takes precedence over a request in the same cycle
  assign cfg_ready = idle;
  assign req_ready = idle && !cfg_valid;

  // Drive datapath commands
  always_comb begin
    cmd           = '0;
    cmd.capture   = req_valid && req_ready;
    cmd.cfg_write = cfg_valid && cfg_ready;
    cmd.match     = (state == S_MATCH);
    cmd.update    = (state == S_UPDATE);
    cmd.finish    = (state == S_FINISH) && !sts.rsp_busy;
  end

  // Advance one step per cycle, hold in finish while the response slot is full
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH:  state_next = S_UPDATE;
      S_UPDATE: state_next = S_FINISH;
      S_FINISH: begin
        if (!sts.rsp_busy) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A request transfer and a configuration transfer never coincide
  a_no_cfg_with_req: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.cfg_write))
    else $error("request and configuration transferred together");

  // A captured request always moves on to the match step
  a_capture_to_match: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.match)
    else $error("captured request did not reach match");

endmodule

// File: hw/rtl/lkv_datapath.sv
// Entry store, lane compare, recency ranks and response register.
module lkv_datapath #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  lkv_pkg::lkv_req_t req,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_capacity,
  input  lkv_pkg::lkv_cmd_t cmd,
  output lkv_pkg::lkv_sts_t sts,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lkv_pkg::lkv_rsp_t rsp
);

  import lkv_pkg::*;

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W   = IDX_W;
  localparam int FILL_W   = $clog2(ENTRIES + 1);
  localparam int KEY_WIDE = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;

  // Request and configuration state
  lkv_req_t             req_q;
  logic [CAP_W-1:0]     capacity;

  // Per-lane entry state
  logic [ENTRIES-1:0]   valid;
  logic [KEY_BITS-1:0]  ekey [ENTRIES];
  logic [RANK_W-1:0]    rank [ENTRIES];
  logic [FILL_W-1:0]    fill;

  // Match step results
  logic [ENTRIES-1:0]   match_q;
  logic [ENTRIES-1:0]   lru_q;

  // Result flags kept for the finish step
  logic                 hit_q;
  logic                 put_q;
  logic                 evict_q;

  // Combinational helpers
  logic [KEY_WIDE-1:0]  key_wide;
  logic [KEY_BITS-1:0]  key_cut;
  logic [RANK_W-1:0]    lru_rank;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     lru_idx;
  logic [IDX_W-1:0]     target;
  logic [RANK_W-1:0]    old_rank;
  logic                 any_hit;
  logic                 is_put;
  logic [CAP_W-1:0]     eff_cap;
  logic                 room;
  logic                 ram_we;
  logic                 ram_re;
  logic [VALUE_BITS-1:0] ram_rdata;

  assign key_wide = KEY_WIDE'(req_q.key);
  assign key_cut  = key_wide[KEY_BITS-1:0];
  assign lru_rank = RANK_W'(fill - FILL_W'(1));
  assign any_hit  = |match_q;
  assign is_put   = (req_q.opcode == OP_PUT);
  assign eff_cap  = (capacity == '0) ? CAP_W'(1) : capacity;
  assign room     = (32'(fill) < 32'(eff_cap)) && (32'(fill) < ENTRIES);

  // Find the first matching lane and the first least-recent lane
  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (lru_q[i]) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  // Pick the entry to touch and the rank it leaves behind
  always_comb begin
    if (any_hit) begin
      target   = hit_idx;
      old_rank = rank[hit_idx];
    end else if (room) begin
      target   = IDX_W'(fill);
      old_rank = RANK_W'(fill);
    end else begin
      target   = lru_idx;
      old_rank = rank[lru_idx];
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(8);
    end else if (cmd.cfg_write) begin
      capacity <= cfg_capacity;
    end
  end

  // Compare every lane in parallel
  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= '0;
      lru_q   <= '0;
    end else if (cmd.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= valid[i] && (ekey[i] == key_cut);
        lru_q[i]   <= valid[i] && (rank[i] == lru_rank);
      end
    end
  end

  // Update valid bits, ranks and fill count; clear them on a capacity write
  always_ff @(posedge clk) begin
    if (rst || cmd.cfg_write) begin
      valid <= '0;
      fill  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.update && (any_hit || is_put)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == target) begin
          rank[i] <= '0;
        end else if (valid[i] && (rank[i] < old_rank)) begin
          rank[i] <= rank[i] + RANK_W'(1);
        end
      end
      if (!any_hit && room) begin
        valid[target] <= 1'b1;
        fill          <= fill + FILL_W'(1);
      end
    end
  end

  // Store the key of a newly placed entry
  always_ff @(posedge clk) begin
    if (cmd.update && is_put && !any_hit) begin
      ekey[target] <= key_cut;
    end
  end

  // Keep the result flags
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_q   <= any_hit;
      put_q   <= is_put;
      evict_q <= is_put && !any_hit && !room;
    end
  end

  // Value store: write on put, read on get hit
  assign ram_we = cmd.update && is_put;
  assign ram_re = cmd.update && !is_put && any_hit;

  lkv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (target),
    .wdata (req_q.value[VALUE_BITS-1:0]),
    .re    (ram_re),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.hit     <= hit_q;
      rsp.evicted <= evict_q;
      if (put_q) begin
        rsp.read_value <= '0;
      end else if (hit_q) begin
        rsp.read_value <= VALUE_W'($signed(ram_rdata));
      end else begin
        rsp.read_value <= '1;
      end
    end
  end

  assign sts.rsp_busy = rsp_valid && !rsp_ready;

  // The fill count never passes the number of entries
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= ENTRIES)
    else $error("fill count beyond entry count");

  // The count of valid lanes always equals the fill count
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(fill))
    else $error("valid bits disagree with fill count");

  // Keys are unique among valid entries, so at most one lane matches
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_q))
    else $error("more than one lane matched");

  // An eviction only happens with the store full (at capacity or at the entry count), so never when empty
  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && is_put && !any_hit && !room) |-> (fill != '0))
    else $error("eviction from an empty store");

endmodule
